/* hw/rtl/warc_pkg.sv */
// shared types, register indexes and constants of the wing angle ramp controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package warc_pkg;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_PEDAL_HIGH   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PEDAL_LOW    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE_INC    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OPEN_ANGLE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CLOSED_ANGLE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_START_ANGLE  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BACKOFF      = 3'd6;

  localparam logic [11:0] PEDAL_HIGH_RST   = 12'd2048;
  localparam logic [11:0] PEDAL_LOW_RST    = 12'd1024;
  localparam logic [11:0] ANGLE_INC_RST    = 12'd16;
  localparam logic [12:0] OPEN_ANGLE_RST   = 13'd320;
  localparam logic [12:0] CLOSED_ANGLE_RST = 13'h1EC0;  // -320
  localparam logic [12:0] START_ANGLE_RST  = 13'd0;
  localparam logic [12:0] BACKOFF_RST      = 13'd0;

  localparam logic [2:0] MODE_OPEN_STEADY   = 3'd0;
  localparam logic [2:0] MODE_OPEN_MOVING   = 3'd1;
  localparam logic [2:0] MODE_CLOSED_STEADY = 3'd2;
  localparam logic [2:0] MODE_CLOSED_MOVING = 3'd3;
  localparam logic [2:0] MODE_STALL         = 3'd4;

  // angle code: (t + 2880) * 8 / 45, with /45 done as a reciprocal multiply
  localparam logic signed [13:0] ANGLE_BIAS = 14'sd2880;
  localparam logic [16:0]        DIV45_RECIP = 17'd93207;  // ceil(2^22 / 45)
  localparam int unsigned        DIV45_SHIFT = 19;         // 22 minus the times-8

  localparam logic signed [14:0] SERVO_MAX = 15'sd8191;

  typedef struct packed {
    logic [11:0] pedal_high_threshold;
    logic [11:0] pedal_low_threshold;
    logic [11:0] angle_increment;
    logic [12:0] open_angle;
    logic [12:0] closed_angle;
    logic [12:0] start_angle;
    logic [12:0] backoff_offset;
  } cfg_t;

endpackage

`default_nettype wire

/* hw/rtl/warc_cfg_regs.sv */
// apb configuration registers of the wing angle ramp controller
// depends on warc_pkg
`timescale 1ns / 1ps
`default_nettype none

module warc_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [warc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [warc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [warc_pkg::APB_DATA_W-1:0]  prdata,
  output warc_pkg::cfg_t                        cfg
);

  logic                              wr_en;
  logic [warc_pkg::REG_IDX_W-1:0]    idx;
  warc_pkg::cfg_t                    regs;

  assign wr_en = psel && penable && pwrite;
  assign idx   = paddr[warc_pkg::APB_ADDR_W-1:2];
  assign cfg   = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pedal_high_threshold <= warc_pkg::PEDAL_HIGH_RST;
      regs.pedal_low_threshold  <= warc_pkg::PEDAL_LOW_RST;
      regs.angle_increment      <= warc_pkg::ANGLE_INC_RST;
      regs.open_angle           <= warc_pkg::OPEN_ANGLE_RST;
      regs.closed_angle         <= warc_pkg::CLOSED_ANGLE_RST;
      regs.start_angle          <= warc_pkg::START_ANGLE_RST;
      regs.backoff_offset       <= warc_pkg::BACKOFF_RST;
    end else if (wr_en) begin
      case (idx)
        warc_pkg::REG_PEDAL_HIGH:   regs.pedal_high_threshold <= pwdata[11:0];
        warc_pkg::REG_PEDAL_LOW:    regs.pedal_low_threshold  <= pwdata[11:0];
        warc_pkg::REG_ANGLE_INC:    regs.angle_increment      <= pwdata[11:0];
        warc_pkg::REG_OPEN_ANGLE:   regs.open_angle           <= pwdata[12:0];
        warc_pkg::REG_CLOSED_ANGLE: regs.closed_angle         <= pwdata[12:0];
        warc_pkg::REG_START_ANGLE:  regs.start_angle          <= pwdata[12:0];
        warc_pkg::REG_BACKOFF:      regs.backoff_offset       <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      warc_pkg::REG_PEDAL_HIGH:   prdata = {20'd0, regs.pedal_high_threshold};
      warc_pkg::REG_PEDAL_LOW:    prdata = {20'd0, regs.pedal_low_threshold};
      warc_pkg::REG_ANGLE_INC:    prdata = {20'd0, regs.angle_increment};
      warc_pkg::REG_OPEN_ANGLE:   prdata = {{19{regs.open_angle[12]}}, regs.open_angle};
      warc_pkg::REG_CLOSED_ANGLE: prdata = {{19{regs.closed_angle[12]}}, regs.closed_angle};
      warc_pkg::REG_START_ANGLE:  prdata = {{19{regs.start_angle[12]}}, regs.start_angle};
      warc_pkg::REG_BACKOFF:      prdata = {19'd0, regs.backoff_offset};
      default:                    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/warc_ramp_core.sv */
// control state and per-item logic: hysteresis, status word, ramp, clamp, stall backoff
// depends on warc_pkg
`timescale 1ns / 1ps
`default_nettype none

module warc_ramp_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire logic [11:0]    pedal_raw,
  input  wire logic           stall_detected,
  input  wire logic [1:0]     memory_status,
  input  wire warc_pkg::cfg_t cfg,
  output logic signed [13:0]  servo_angle,
  output logic [15:0]         status_word
);

  logic               wing_open;
  logic signed [12:0] target_angle;
  logic [2:0]         motion_mode;
  logic               stall_latched;

  logic               wing_open_next;
  logic signed [12:0] target_angle_next;
  logic [2:0]         motion_mode_next;
  logic               stall_latched_next;

  logic signed [14:0] tgt_w;
  logic signed [14:0] inc_w;
  logic signed [14:0] off_w;
  logic signed [14:0] open_w;
  logic signed [14:0] closed_w;
  logic signed [14:0] up_sum;
  logic signed [14:0] down_sum;
  logic signed [14:0] backoff;
  logic signed [14:0] backoff_floor;
  logic signed [14:0] backoff_sat;

  logic signed [13:0] biased;
  logic               biased_neg;
  logic [12:0]        biased_mag;
  logic [29:0]        recip_prod;
  logic [10:0]        quot;
  logic [9:0]         code;

  // angle code of the current target
  always_comb begin
    biased     = 14'(tgt_w) + warc_pkg::ANGLE_BIAS;
    biased_neg = biased[13];
    biased_mag = biased_neg ? 13'(-biased) : biased[12:0];
    recip_prod = 30'(biased_mag) * 30'(warc_pkg::DIV45_RECIP);
    quot       = recip_prod[warc_pkg::DIV45_SHIFT +: 11];
    code       = biased_neg ? 10'(-quot) : quot[9:0];
  end

  always_comb begin
    tgt_w    = 15'(target_angle);
    inc_w    = $signed({3'b000, cfg.angle_increment});
    off_w    = $signed({2'b00, cfg.backoff_offset});
    open_w   = 15'($signed(cfg.open_angle));
    closed_w = 15'($signed(cfg.closed_angle));
    up_sum   = tgt_w + inc_w;
    down_sum = tgt_w - inc_w;

    if (motion_mode == warc_pkg::MODE_OPEN_MOVING || motion_mode == warc_pkg::MODE_OPEN_STEADY) begin
      backoff = tgt_w - off_w;
    end else begin
      backoff = tgt_w + off_w;
    end
    backoff_floor = (backoff < closed_w) ? closed_w : backoff;
    backoff_sat   = (backoff_floor > warc_pkg::SERVO_MAX) ? warc_pkg::SERVO_MAX : backoff_floor;

    if (!wing_open && pedal_raw >= cfg.pedal_high_threshold) begin
      wing_open_next = 1'b1;
    end else if (wing_open && pedal_raw <= cfg.pedal_low_threshold) begin
      wing_open_next = 1'b0;
    end else begin
      wing_open_next = wing_open;
    end

    status_word = {stall_latched, memory_status, motion_mode, code};

    target_angle_next  = target_angle;
    stall_latched_next = stall_latched;
    motion_mode_next   = motion_mode;
    if (stall_latched) begin
      motion_mode_next = warc_pkg::MODE_STALL;
      servo_angle      = backoff_sat[13:0];
    end else begin
      stall_latched_next = stall_detected;
      if (wing_open_next) begin
        if (up_sum > open_w) begin
          target_angle_next = cfg.open_angle;
          motion_mode_next  = warc_pkg::MODE_OPEN_STEADY;
        end else begin
          target_angle_next = up_sum[12:0];
          motion_mode_next  = warc_pkg::MODE_OPEN_MOVING;
        end
      end else begin
        if (down_sum < closed_w) begin
          target_angle_next = cfg.closed_angle;
          motion_mode_next  = warc_pkg::MODE_CLOSED_STEADY;
        end else begin
          target_angle_next = down_sum[12:0];
          motion_mode_next  = warc_pkg::MODE_CLOSED_MOVING;
        end
      end
      servo_angle = 14'(target_angle_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wing_open     <= 1'b0;
      target_angle  <= warc_pkg::START_ANGLE_RST;
      motion_mode   <= warc_pkg::MODE_OPEN_STEADY;
      stall_latched <= 1'b0;
    end else if (step) begin
      wing_open     <= wing_open_next;
      target_angle  <= target_angle_next;
      motion_mode   <= motion_mode_next;
      stall_latched <= stall_latched_next;
    end
  end

`ifndef SYNTHESIS
  a_latch_holds: assert property (@(posedge clk) disable iff (rst)
    stall_latched |=> stall_latched)
    else $error("stall latch cleared without reset");
  a_target_frozen: assert property (@(posedge clk) disable iff (rst)
    stall_latched |=> $stable(target_angle))
    else $error("target moved while stalled");
  a_stall_mode: assert property (@(posedge clk) disable iff (rst)
    (step && stall_latched) |=> motion_mode == warc_pkg::MODE_STALL)
    else $error("mode not stall after latched item");
  a_open_clamp: assert property (@(posedge clk) disable iff (rst)
    (step && !stall_latched && wing_open_next)
      |=> target_angle <= $signed($past(cfg.open_angle)))
    else $error("target above open angle");
`endif

endmodule

`default_nettype wire

/* hw/rtl/wing_angle_ramp_controller.sv */
// Wing angle ramp controller. Takes one item per clock cycle when the result side keeps up.
// Each item passes an input register, then the ramp logic (hysteresis, angle code with one
// reciprocal multiply, ramp and clamp) in a single pass, then the result register. The input
// register takes one more item while a result waits to be taken. Angles are signed sixteenths
// of a degree; the stall latch only clears on reset. The user writes registers over the APB
// port only while no item is in flight; the block itself does not enforce this.
// depends on warc_pkg, warc_cfg_regs, warc_ramp_core
`timescale 1ns / 1ps
`default_nettype none

module wing_angle_ramp_controller (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [15:0]                      s_tdata,   // pedal_raw, memory_status
  input  wire logic                             s_tuser,   // stall_detected
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [31:0]                           m_tdata,   // servo_angle, status_word
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [warc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [warc_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [warc_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready
);

  warc_pkg::cfg_t     cfg;
  logic               in_valid;
  logic [11:0]        in_pedal;
  logic               in_stall;
  logic [1:0]         in_mem;
  logic               advance;
  logic               s_accept;
  logic signed [13:0] core_servo;
  logic [15:0]        core_status;
  logic signed [13:0] out_servo;
  logic [15:0]        out_status;

  assign pready   = 1'b1;
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign s_accept = s_tvalid && s_tready;
  assign m_tdata  = {2'b00, out_status, out_servo};

  warc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  warc_ramp_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .pedal_raw      (in_pedal),
    .stall_detected (in_stall),
    .memory_status  (in_mem),
    .cfg            (cfg),
    .servo_angle    (core_servo),
    .status_word    (core_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (s_accept) begin
      in_pedal <= s_tdata[11:0];
      in_mem   <= s_tdata[13:12];
      in_stall <= s_tuser;
    end
    if (advance) begin
      out_servo  <= core_servo;
      out_status <= core_status;
    end
  end

endmodule

`default_nettype wire
